@@ hdl/llgmn_pkg.sv @@
// Package for the LLGMN classifier: constants, word types, exp2 table.
// No dependencies.
`default_nettype none
package llgmn_pkg;
	localparam int FEATURES_DEF = 4;
	localparam int TERMS_DEF = 15;
	localparam int COMPONENTS_DEF = 2;
	localparam int CLASSES_DEF = 4;
	localparam logic [16:0] LOG2E_Q16 = 17'd94548;
	localparam logic [15:0] ONE_Q12 = 16'd4096;
	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_CLASSIFY = 1'b1;

	typedef struct packed {
		logic mode;
		logic [3:0] weight_row;
		logic [2:0] weight_col;
		logic signed [23:0] weight_value;
		logic signed [15:0] feature_0;
		logic signed [15:0] feature_1;
		logic signed [15:0] feature_2;
		logic signed [15:0] feature_3;
	} in_word_t;

	typedef struct packed {
		logic [15:0] prob_0;
		logic [15:0] prob_1;
		logic [15:0] prob_2;
		logic [15:0] prob_3;
		logic [1:0] best_class;
	} out_word_t;

	function automatic logic [16:0] exp2_tab(input logic [4:0] j);
		logic [16:0] v;
		case (j)
			5'd0: v = 17'd65536;
			5'd1: v = 17'd62757;
			5'd2: v = 17'd60097;
			5'd3: v = 17'd57549;
			5'd4: v = 17'd55109;
			5'd5: v = 17'd52773;
			5'd6: v = 17'd50535;
			5'd7: v = 17'd48393;
			5'd8: v = 17'd46341;
			5'd9: v = 17'd44376;
			5'd10: v = 17'd42495;
			5'd11: v = 17'd40693;
			5'd12: v = 17'd38968;
			5'd13: v = 17'd37316;
			5'd14: v = 17'd35734;
			5'd15: v = 17'd34219;
			default: v = 17'd32768;
		endcase
		return v;
	endfunction
endpackage
`default_nettype wire

@@ hdl/llgmn_ram.sv @@
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
`default_nettype none
module llgmn_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 120
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ hdl/llgmn_classifier_inference_top.sv @@
// LLGMN classifier top: weight store, sequencer, one shared multiply unit.
// Depends on llgmn_pkg and llgmn_ram.
// Reset clears control; a clearing pass then zeroes all TERMS*UNITS store entries (120 at
// defaults), stall high meanwhile. A weight write is accepted only while idle. A sample
// raises out_valid after the basis build, the dot products (registered store read), the
// exp per unit, a 33-step divider and normalisation; an unaccepted prior result delays it.
`default_nettype none
module llgmn_classifier_inference_top #(
	parameter int FEATURES = llgmn_pkg::FEATURES_DEF,
	parameter int TERMS = llgmn_pkg::TERMS_DEF,
	parameter int COMPONENTS = llgmn_pkg::COMPONENTS_DEF,
	parameter int CLASSES = llgmn_pkg::CLASSES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire llgmn_pkg::in_word_t in_word,
	output logic out_valid,
	input wire logic out_stall,
	output llgmn_pkg::out_word_t out_word
);
	import llgmn_pkg::*;

	localparam int UNITS = CLASSES * COMPONENTS;
	localparam int DEPTH = TERMS * UNITS;
	localparam int AW = $clog2(DEPTH);
	localparam int TW = $clog2(TERMS);
	localparam int UW = $clog2(UNITS);
	localparam int CW = $clog2(CLASSES);
	localparam int MW = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;
	localparam int FW = $clog2(FEATURES + 1);
	localparam int FIW = (FEATURES > 1) ? $clog2(FEATURES) : 1;

	localparam logic [3:0] ST_CLR = 4'd0, ST_IDLE = 4'd1, ST_BAS_A = 4'd2, ST_MAC_A = 4'd3,
		ST_MAC_W = 4'd4, ST_MAC_M = 4'd5, ST_EXP_D = 4'd6, ST_EXP_I = 4'd7,
		ST_DIV = 4'd8, ST_NRM = 4'd9, ST_OUT = 4'd11;

	logic [3:0] state_q;
	logic [AW-1:0] clr_q;
	logic [TW-1:0] t_q;
	logic [UW-1:0] u_q;
	logic [UW-1:0] k_q;
	logic [CW-1:0] c_q;
	logic [MW-1:0] m_q;
	logic [FW-1:0] fi_q, fj_q;
	logic [5:0] div_q;
	logic signed [15:0] feat_q [FEATURES];
	logic signed [31:0] basis_q [TERMS];
	logic signed [63:0] acc_q;
	logic signed [63:0] sums_q [UNITS];
	logic signed [63:0] mx_q;
	logic [16:0] ev_q [UNITS];
	logic [20:0] s_q;
	logic [32:0] rem_q;
	logic [32:0] r_q;
	logic [16:0] p_q;
	logic [15:0] prob_q [CLASSES];
	logic [16:0] bestp_q;
	logic [CW-1:0] best_q;
	logic signed [47:0] mul_q;
	out_word_t out_q;
	logic ovalid_q;

	// shared multiplier
	logic signed [33:0] ma, mb;
	logic signed [67:0] mprod;
	assign mprod = ma * mb;

	logic ram_we;
	logic [AW-1:0] ram_wa, ram_ra;
	logic [23:0] ram_wd, ram_rd;

	llgmn_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_store (
		.clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
		.raddr(ram_ra), .rdata(ram_rd)
	);

	logic in_ok;
	assign in_stall = (state_q != ST_IDLE);
	assign in_ok = in_valid && !in_stall;

	always_comb begin
		ram_we = 1'b0;
		ram_wa = clr_q;
		ram_wd = '0;
		if (state_q == ST_CLR) begin
			ram_we = 1'b1;
		end else if (in_ok && in_word.mode == MODE_WRITE
				&& 32'(in_word.weight_row) < TERMS
				&& 32'(in_word.weight_col) < UNITS) begin
			ram_we = 1'b1;
			ram_wa = AW'(32'(in_word.weight_row) * UNITS + 32'(in_word.weight_col));
			ram_wd = in_word.weight_value;
		end
	end
	assign ram_ra = AW'(32'(t_q) * UNITS + 32'(u_q));

	// exp datapath pieces
	logic [63:0] dcur;
	always_comb dcur = 64'(mx_q - sums_q[k_q]) >> 12;
	logic [31:0] y;
	logic [3:0] jj;
	logic [11:0] lo;
	logic [15:0] ip;
	logic [16:0] t0, t1, vint;
	assign y = mul_q[47:16];
	assign ip = y[31:16];
	assign jj = y[15:12];
	assign lo = y[11:0];
	assign t0 = exp2_tab({1'b0, jj});
	assign t1 = exp2_tab({1'b0, jj} + 5'd1);
	assign vint = t0 - 17'(mprod[67:12]);

	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			ST_BAS_A: begin
				ma = 34'(feat_q[fi_q[FIW-1:0]]);
				mb = 34'(feat_q[fj_q[FIW-1:0]]);
			end
			ST_MAC_M: begin
				ma = 34'(signed'(ram_rd));
				mb = 34'(basis_q[t_q]);
			end
			ST_EXP_D: begin
				ma = 34'(dcur[20:0]);
				mb = 34'(LOG2E_Q16);
			end
			ST_EXP_I: begin
				ma = 34'(t0 - t1);
				mb = 34'(lo);
			end
			ST_NRM: begin
				ma = 34'(ev_q[k_q]);
				mb = 34'(r_q);
			end
			default: ;
		endcase
	end

	logic [32:0] rem_sh;
	assign rem_sh = {rem_q[31:0], div_q == 6'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q <= '0;
			ovalid_q <= 1'b0;
			t_q <= '0;
			u_q <= '0;
			k_q <= '0;
		end else begin
			if (ovalid_q && !out_stall) ovalid_q <= 1'b0;
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == DEPTH - 1) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_ok && in_word.mode == MODE_CLASSIFY) begin
						feat_q[0] <= in_word.feature_0;
						if (FEATURES > 1) feat_q[FEATURES > 1 ? 1 : 0] <= in_word.feature_1;
						if (FEATURES > 2) feat_q[FEATURES > 2 ? 2 : 0] <= in_word.feature_2;
						if (FEATURES > 3) feat_q[FEATURES > 3 ? 3 : 0] <= in_word.feature_3;
						for (int i = 4; i < FEATURES; i++) feat_q[i] <= '0;
						for (int i = 0; i < TERMS; i++) basis_q[i] <= '0;
						basis_q[0] <= 32'(ONE_Q12);
						t_q <= TW'(1);
						fi_q <= '0;
						fj_q <= '0;
						state_q <= ST_BAS_A;
					end
				end
				ST_BAS_A: begin
					// linear terms first, then products i<=j
					if (32'(t_q) <= FEATURES) begin
						if (32'(t_q) < TERMS)
							basis_q[t_q] <= 32'(feat_q[FIW'(t_q - 1'b1)]);
						t_q <= t_q + 1'b1;
					end else begin
						if (32'(t_q) < TERMS)
							basis_q[t_q] <= 32'(mprod[67:12]);
						t_q <= t_q + 1'b1;
						if (32'(fj_q) == FEATURES - 1) begin
							fi_q <= fi_q + 1'b1;
							fj_q <= fi_q + 1'b1;
						end else begin
							fj_q <= fj_q + 1'b1;
						end
					end
					if (32'(t_q) >= TERMS - 1 || (32'(fi_q) == FEATURES - 1 &&
							32'(fj_q) == FEATURES - 1 && 32'(t_q) > FEATURES)) begin
						t_q <= '0;
						u_q <= '0;
						acc_q <= '0;
						state_q <= ST_MAC_A;
					end
				end
				ST_MAC_A: state_q <= ST_MAC_W;
				ST_MAC_W: state_q <= ST_MAC_M;
				ST_MAC_M: begin
					if (32'(t_q) == TERMS - 1) begin
						sums_q[u_q] <= acc_q + 64'(mprod);
						if (u_q == 0 || acc_q + 64'(mprod) > mx_q) mx_q <= acc_q + 64'(mprod);
						acc_q <= '0;
						t_q <= '0;
						if (32'(u_q) == UNITS - 1) begin
							k_q <= '0;
							s_q <= '0;
							state_q <= ST_EXP_D;
						end else begin
							u_q <= u_q + 1'b1;
							state_q <= ST_MAC_A;
						end
					end else begin
						acc_q <= acc_q + 64'(mprod);
						t_q <= t_q + 1'b1;
						state_q <= ST_MAC_A;
					end
				end
				ST_EXP_D: begin
					mul_q <= 48'(mprod);
					if (dcur >= 64'(20'hFFFFF) + 64'd1) begin
						ev_q[k_q] <= '0;
						k_q <= k_q + 1'b1;
						if (32'(k_q) == UNITS - 1) begin
							div_q <= '0;
							rem_q <= '0;
							r_q <= '0;
							state_q <= ST_DIV;
						end
					end else begin
						state_q <= ST_EXP_I;
					end
				end
				ST_EXP_I: begin
					ev_q[k_q] <= (ip >= 16'd17) ? '0 : 17'(vint >> ip);
					s_q <= s_q + 21'((ip >= 16'd17) ? '0 : (vint >> ip));
					k_q <= k_q + 1'b1;
					if (32'(k_q) == UNITS - 1) begin
						div_q <= '0;
						rem_q <= '0;
						r_q <= '0;
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_EXP_D;
					end
				end
				ST_DIV: begin
					// restoring division of 2^32 by S, one quotient bit per cycle
					if (rem_sh >= 33'(s_q)) begin
						rem_q <= rem_sh - 33'(s_q);
						r_q <= {r_q[31:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						r_q <= {r_q[31:0], 1'b0};
					end
					div_q <= div_q + 1'b1;
					if (div_q == 6'd32) begin
						k_q <= '0;
						c_q <= '0;
						m_q <= '0;
						p_q <= '0;
						best_q <= '0;
						bestp_q <= '0;
						state_q <= ST_NRM;
					end
				end
				ST_NRM: begin
					// p_q saturates: sum of COMPONENTS terms per class, each < 2^17
					logic [20:0] np;
					logic [15:0] sp;
					np = 21'(p_q) + 21'(mprod[67:16]);
					sp = (np > 21'd65535) ? 16'hFFFF : np[15:0];
					k_q <= k_q + 1'b1;
					if (32'(m_q) == COMPONENTS - 1) begin
						p_q <= '0;
						m_q <= '0;
						c_q <= c_q + 1'b1;
						prob_q[c_q] <= sp;
						if (c_q == 0 || 17'(sp) > bestp_q) begin
							bestp_q <= 17'(sp);
							best_q <= c_q;
						end
					end else begin
						m_q <= m_q + 1'b1;
						p_q <= (np > 21'd65535) ? 17'd65536 : np[16:0];
					end
					if (32'(k_q) == UNITS - 1) state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!ovalid_q) begin
						out_q.prob_0 <= prob_q[0];
						out_q.prob_1 <= prob_q[1];
						out_q.prob_2 <= (CLASSES > 2) ? prob_q[CLASSES > 2 ? 2 : 0] : '0;
						out_q.prob_3 <= (CLASSES > 3) ? prob_q[CLASSES > 3 ? 3 : 0] : '0;
						out_q.best_class <= 2'(best_q);
						ovalid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = ovalid_q;
	assign out_word = out_q;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall) else $error("accept while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_word)))
		else $error("result dropped");
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (div_q <= 6'd32)) else $error("divider overrun");
endmodule
`default_nettype wire
